@@ rtl/lpd_pkg.sv @@
package lpd_pkg;

  localparam int unsigned N           = 4;
  localparam int unsigned Q           = 97;
  localparam int unsigned HALF        = Q / 2;
  localparam int unsigned QUARTER     = Q / 4;
  localparam int unsigned COEF_W      = 7;
  localparam int unsigned PROD_W      = 2 * COEF_W;
  localparam int unsigned ACC_W       = 17;
  localparam int unsigned QUOT_W      = 10;
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned RECIP       = (1 << RECIP_SHIFT) / Q;
  localparam int unsigned RECIP_W     = 18;
  localparam int unsigned MUL_W       = ACC_W + RECIP_W;
  localparam int unsigned ACC_OFFSET  = N * Q * Q;
  localparam int unsigned REM_W       = 8;

  typedef logic [COEF_W-1:0]  coef_t;
  typedef coef_t [N-1:0]      coef_vec_t;
  typedef logic [PROD_W-1:0]  prod_t;
  typedef logic [ACC_W-1:0]   acc_t;
  typedef logic [QUOT_W-1:0]  quot_t;

  typedef struct packed {
    logic en_prod;
    logic en_sum;
    logic en_quot;
  } lane_ctl_t;

  function automatic coef_t reduce_coef(input coef_t c);
    coef_t r;
    r = (c >= coef_t'(Q)) ? coef_t'(c - coef_t'(Q)) : c;
    return r;
  endfunction

endpackage

@@ rtl/lpd_lane.sv @@
module lpd_lane (
  input  logic                clk_i,
  input  lpd_pkg::lane_ctl_t  ctl_i,
  input  lpd_pkg::coef_vec_t  s_i,
  input  lpd_pkg::coef_vec_t  u_i,
  input  lpd_pkg::coef_t      v_i,
  input  logic [lpd_pkg::N-1:0] neg_i,
  output logic                bit_o
);
  import lpd_pkg::*;

  prod_t [N-1:0] prod_q;
  coef_t         v_q;
  acc_t          sum_d, sum_q;
  acc_t          x_q;
  quot_t         quot_q;
  logic [MUL_W-1:0] mul;
  logic [ACC_W-1:0] qmul;
  logic [ACC_W-1:0] rem_full;
  logic [REM_W-1:0] rem;
  coef_t         p;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en_prod) begin
      for (int i = 0; i < N; i++) begin
        prod_q[i] <= prod_t'(s_i[i]) * prod_t'(u_i[i]);
      end
      v_q <= v_i;
    end
  end

  // offset keeps the signed sum nonnegative; it is a multiple of Q
  always_comb begin
    sum_d = acc_t'(ACC_OFFSET) + acc_t'(v_q);
    for (int i = 0; i < N; i++) begin
      if (neg_i[i]) sum_d = sum_d + acc_t'(prod_q[i]);
      else          sum_d = sum_d - acc_t'(prod_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en_sum) begin
      sum_q <= sum_d;
    end
  end

  assign mul = MUL_W'(sum_q) * MUL_W'(RECIP);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en_quot) begin
      quot_q <= mul[RECIP_SHIFT +: QUOT_W];
      x_q    <= sum_q;
    end
  end

  // quotient estimate is low by at most one
  always_comb begin
    qmul     = ACC_W'(quot_q) * ACC_W'(Q);
    rem_full = x_q - qmul;
    rem      = rem_full[REM_W-1:0];
    if (rem >= REM_W'(Q)) rem = rem - REM_W'(Q);
    p = rem[COEF_W-1:0];
    if (p > coef_t'(HALF)) bit_o = (coef_t'(Q) - p) > coef_t'(QUARTER);
    else                   bit_o = p > coef_t'(QUARTER);
  end

endmodule

@@ rtl/lpd_merge.sv @@
module lpd_merge (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [lpd_pkg::N-1:0] bits_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [lpd_pkg::N-1:0] plaintext_o
);
  import lpd_pkg::*;

  logic         valid_q;
  logic [N-1:0] plain_q;

  assign ready_o     = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign plaintext_o = plain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      plain_q <= bits_i;
    end
  end

endmodule

@@ rtl/lattice_poly_decrypt_q97_n4_core.sv @@
// Channel  Direction  Signals
// in       input      in_valid_i / in_ready_o, s_coef0..3_i, u_coef0..3_i, v_coef0..3_i
// out      output     out_valid_o / out_ready_i, plaintext_o
//
// One item per cycle while the output does not stall.
// Stages: input reduction, lane products, signed sum, reciprocal multiply,
// remainder and threshold into the output register.
// Reset clears the stage valid bits only.
// Each stage holds only while full and the one after it holds.
module lattice_poly_decrypt_q97_n4_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [6:0]          s_coef0_i,
  input  logic [6:0]          s_coef1_i,
  input  logic [6:0]          s_coef2_i,
  input  logic [6:0]          s_coef3_i,
  input  logic [6:0]          u_coef0_i,
  input  logic [6:0]          u_coef1_i,
  input  logic [6:0]          u_coef2_i,
  input  logic [6:0]          u_coef3_i,
  input  logic [6:0]          v_coef0_i,
  input  logic [6:0]          v_coef1_i,
  input  logic [6:0]          v_coef2_i,
  input  logic [6:0]          v_coef3_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [3:0]          plaintext_o
);
  import lpd_pkg::*;

  coef_vec_t    s_q, u_q, v_q;
  logic [3:0]   valid_q;
  logic [3:0]   en;
  logic         merge_ready;
  lane_ctl_t    ctl;
  logic [N-1:0] bits;

  assign en[3] = !valid_q[3] || merge_ready;
  assign en[2] = !valid_q[2] || en[3];
  assign en[1] = !valid_q[1] || en[2];
  assign en[0] = !valid_q[0] || en[1];
  assign in_ready_o = en[0];

  assign ctl.en_prod = en[1];
  assign ctl.en_sum  = en[2];
  assign ctl.en_quot = en[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= in_valid_i;
      if (en[1]) valid_q[1] <= valid_q[0];
      if (en[2]) valid_q[2] <= valid_q[1];
      if (en[3]) valid_q[3] <= valid_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && in_valid_i) begin
      s_q[0] <= reduce_coef(s_coef0_i);
      s_q[1] <= reduce_coef(s_coef1_i);
      s_q[2] <= reduce_coef(s_coef2_i);
      s_q[3] <= reduce_coef(s_coef3_i);
      u_q[0] <= reduce_coef(u_coef0_i);
      u_q[1] <= reduce_coef(u_coef1_i);
      u_q[2] <= reduce_coef(u_coef2_i);
      u_q[3] <= reduce_coef(u_coef3_i);
      v_q[0] <= reduce_coef(v_coef0_i);
      v_q[1] <= reduce_coef(v_coef1_i);
      v_q[2] <= reduce_coef(v_coef2_i);
      v_q[3] <= reduce_coef(v_coef3_i);
    end
  end

  // lane k pairs s[i] with u[(k-i) mod N]; wrapped terms enter negated
  for (genvar k = 0; k < N; k++) begin : g_lane
    coef_vec_t    u_rot;
    logic [N-1:0] neg;
    for (genvar i = 0; i < N; i++) begin : g_pair
      assign u_rot[i] = u_q[(k - i + N) % N];
      assign neg[i]   = (i > k);
    end
    lpd_lane u_lane (
      .clk_i (clk_i),
      .ctl_i (ctl),
      .s_i   (s_q),
      .u_i   (u_rot),
      .v_i   (v_q[k]),
      .neg_i (neg),
      .bit_o (bits[k])
    );
  end

  lpd_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_q[3]),
    .ready_o     (merge_ready),
    .bits_i      (bits),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .plaintext_o (plaintext_o)
  );

endmodule

@@ tb/sv/tb_lattice_poly_decrypt_q97_n4_core.sv @@
`timescale 1ns / 100ps

module tb_lattice_poly_decrypt_q97_n4_core;
  import lpd_pkg::*;

  localparam int unsigned NUM_RANDOM   = 1300;
  localparam int unsigned PAUSE_AT     = 700;
  localparam int unsigned HOLD_AT      = 400;
  localparam int unsigned HOLD_CYCLES  = 120;
  localparam int unsigned MAX_GAP      = 10;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned CORNER[11]   = '{0, 1, 24, 25, 48, 49, 72, 73, 96, 97, 127};

  typedef struct {
    coef_vec_t   s;
    coef_vec_t   u;
    coef_vec_t   v;
    bit          typed;
    logic [3:0]  pt;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  coef_vec_t  s_drv = '0;
  coef_vec_t  u_drv = '0;
  coef_vec_t  v_drv = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [3:0] plaintext_o;

  logic [3:0]  pending_plaintext_q[$];
  stim_row_t   dir_rows[$];
  int unsigned mismatch_count = 0;
  int unsigned tx_burst = 0;

  lattice_poly_decrypt_q97_n4_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .s_coef0_i   (s_drv[0]),
    .s_coef1_i   (s_drv[1]),
    .s_coef2_i   (s_drv[2]),
    .s_coef3_i   (s_drv[3]),
    .u_coef0_i   (u_drv[0]),
    .u_coef1_i   (u_drv[1]),
    .u_coef2_i   (u_drv[2]),
    .u_coef3_i   (u_drv[3]),
    .v_coef0_i   (v_drv[0]),
    .v_coef1_i   (v_drv[1]),
    .v_coef2_i   (v_drv[2]),
    .v_coef3_i   (v_drv[3]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .plaintext_o (plaintext_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned residue(input coef_t c);
    return int'(c) % Q;
  endfunction

  function automatic coef_vec_t vec4(input int unsigned c0, c1, c2, c3);
    coef_vec_t r;
    r[0] = coef_t'(c0);
    r[1] = coef_t'(c1);
    r[2] = coef_t'(c2);
    r[3] = coef_t'(c3);
    return r;
  endfunction

  // X^4 = -1: wrapped terms subtract
  function automatic coef_vec_t negacyclic_mul(input coef_vec_t a, input coef_vec_t b);
    int unsigned acc[N];
    int unsigned term;
    int unsigned k;
    int unsigned i;
    int unsigned j;
    coef_vec_t   prod;
    for (i = 0; i < N; i++) acc[i] = 0;
    for (i = 0; i < N; i++) begin
      for (j = 0; j < N; j++) begin
        term = (residue(a[i]) * residue(b[j])) % Q;
        k = i + j;
        if (k >= N) begin
          k = k - N;
          term = (Q - term) % Q;
        end
        acc[k] = (acc[k] + term) % Q;
      end
    end
    for (i = 0; i < N; i++) prod[i] = coef_t'(acc[i]);
    return prod;
  endfunction

  function automatic logic [3:0] decode_plaintext(input coef_vec_t s, u, v);
    coef_vec_t   prod;
    int unsigned p;
    int unsigned mag;
    int unsigned i;
    logic [3:0]  pt;
    prod = negacyclic_mul(s, u);
    for (i = 0; i < N; i++) begin
      p = (residue(v[i]) + Q - int'(prod[i])) % Q;
      mag = (p > HALF) ? Q - p : p;
      pt[i] = (mag > QUARTER);
    end
    return pt;
  endfunction

  task automatic report_mismatch(input string what, input logic [3:0] got, want);
    $display("ERROR at %0t ns: %s: plaintext got %h want %h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_item(input coef_vec_t s, u, v, input bit typed, input logic [3:0] pt);
    int unsigned gap;
    if (tx_burst > 0) begin
      gap = 0;
      tx_burst--;
    end else begin
      gap = $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 39) == 0) tx_burst = $urandom_range(20, 80);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    s_drv <= s;
    u_drv <= u;
    v_drv <= v;
    do @(posedge clk_i); while (!in_ready_o);
    pending_plaintext_q.push_back(typed ? pt : decode_plaintext(s, u, v));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_plaintext_q.size() != 0);
  endtask

  // half well-formed ciphertexts with noise around the decision thresholds; the rest random or corner values
  task automatic gen_item(output coef_vec_t s, u, v);
    int unsigned mode;
    int unsigned i;
    int          val;
    logic [3:0]  msg;
    coef_vec_t   prod;
    mode = $urandom_range(0, 19);
    for (i = 0; i < N; i++) begin
      if (mode < 10) begin
        case ($urandom_range(0, 2))
          0: s[i] = coef_t'(0);
          1: s[i] = coef_t'(1);
          default: s[i] = coef_t'(Q - 1);
        endcase
        u[i] = coef_t'($urandom_range(0, Q - 1));
      end else if (mode < 15) begin
        s[i] = coef_t'($urandom_range(0, Q - 1));
        u[i] = coef_t'($urandom_range(0, Q - 1));
        v[i] = coef_t'($urandom_range(0, Q - 1));
      end else if (mode < 18) begin
        s[i] = coef_t'($urandom_range(0, 127));
        u[i] = coef_t'($urandom_range(0, 127));
        v[i] = coef_t'($urandom_range(0, 127));
      end else begin
        s[i] = coef_t'(CORNER[$urandom_range(0, 10)]);
        u[i] = coef_t'(CORNER[$urandom_range(0, 10)]);
        v[i] = coef_t'(CORNER[$urandom_range(0, 10)]);
      end
    end
    if (mode < 10) begin
      msg = 4'($urandom_range(0, 15));
      prod = negacyclic_mul(s, u);
      for (i = 0; i < N; i++) begin
        val = int'(prod[i]) + (msg[i] ? int'(HALF) : 0) + $signed($urandom_range(0, 60)) - 30;
        val = ((val % int'(Q)) + int'(Q)) % int'(Q);
        if (val < 31 && $urandom_range(0, 7) == 0) val = val + int'(Q);
        v[i] = coef_t'(val);
      end
    end
  endtask

  initial begin
    int unsigned stall;
    int unsigned rx_burst;
    int unsigned rx_count;
    rx_burst = 0;
    rx_count = 0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (rx_count == HOLD_AT) begin
        stall = HOLD_CYCLES;
      end else if (rx_burst > 0) begin
        stall = 0;
        rx_burst--;
      end else begin
        stall = $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 39) == 0) rx_burst = $urandom_range(20, 80);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      rx_count++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_plaintext_q.size() == 0) begin
        report_mismatch("result with nothing pending", plaintext_o, 4'bxxxx);
      end else if (plaintext_o !== pending_plaintext_q[0]) begin
        report_mismatch("wrong result", plaintext_o, pending_plaintext_q.pop_front());
      end else begin
        void'(pending_plaintext_q.pop_front());
      end
    end
  end

  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
    end
    $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    coef_vec_t   s;
    coef_vec_t   u;
    coef_vec_t   v;
    int unsigned n;

    dir_rows.push_back('{vec4(0, 0, 0, 0), vec4(0, 0, 0, 0), vec4(0, 0, 0, 0), 1'b1, 4'b0000});
    dir_rows.push_back('{vec4(0, 0, 0, 0), vec4(0, 0, 0, 0), vec4(24, 25, 72, 73), 1'b1, 4'b0110});
    dir_rows.push_back('{vec4(0, 0, 0, 0), vec4(0, 0, 0, 0), vec4(127, 97, 96, 48), 1'b1, 4'b1001});
    dir_rows.push_back('{vec4(0, 0, 0, 0), vec4(0, 0, 0, 0), vec4(49, 23, 74, 0), 1'b1, 4'b0001});
    dir_rows.push_back('{vec4(0, 0, 0, 1), vec4(0, 30, 0, 0), vec4(30, 0, 0, 0), 1'b1, 4'b0001});
    dir_rows.push_back('{vec4(1, 0, 0, 0), vec4(25, 0, 0, 0), vec4(0, 0, 0, 0), 1'b1, 4'b0001});
    dir_rows.push_back('{vec4(96, 0, 0, 0), vec4(10, 20, 30, 40), vec4(0, 0, 0, 0), 1'b1, 4'b1100});
    dir_rows.push_back('{vec4(96, 96, 96, 96), vec4(96, 96, 96, 96), vec4(96, 96, 96, 96), 1'b0, 4'b0});
    dir_rows.push_back('{vec4(127, 127, 127, 127), vec4(127, 127, 127, 127),
                         vec4(127, 127, 127, 127), 1'b0, 4'b0});
    dir_rows.push_back('{vec4(1, 1, 1, 1), vec4(96, 96, 96, 96), vec4(48, 49, 0, 96), 1'b0, 4'b0});
    dir_rows.push_back('{vec4(85, 42, 85, 42), vec4(42, 85, 42, 85), vec4(85, 42, 127, 97), 1'b0, 4'b0});
    dir_rows.push_back('{vec4(127, 96, 97, 0), vec4(0, 97, 96, 127), vec4(24, 25, 48, 49), 1'b0, 4'b0});
    dir_rows.push_back('{vec4(0, 1, 2, 3), vec4(3, 2, 1, 0), vec4(72, 73, 24, 25), 1'b0, 4'b0});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].s, dir_rows[i].u, dir_rows[i].v, dir_rows[i].typed, dir_rows[i].pt);
    end

    for (n = 0; n < NUM_RANDOM; n++) begin
      if (n == PAUSE_AT) wait_drained();
      gen_item(s, u, v);
      send_item(s, u, v, 1'b0, 4'b0);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
